@@ rtl/core/cdll_pkg.sv @@
// cdll_pkg: shared types, codes and sizes for the circular doubly linked list engine
// no dependencies; used by circular_doubly_linked_list_engine_unit

package cdll_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int VAL_W        = 32;
    localparam int POS_W        = 6;
    localparam int LEN_W        = 6;

    // request codes
    localparam logic [1:0] REQ_HEAD  = 2'd0;
    localparam logic [1:0] REQ_TAIL  = 2'd1;
    localparam logic [1:0] REQ_AFTER = 2'd2;
    localparam logic [1:0] REQ_DUMP  = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } cdll_req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] element;
        logic [LEN_W-1:0]        length;
        logic                    last;
    } cdll_rsp_t;

endpackage

@@ rtl/core/circular_doubly_linked_list_engine_unit.sv @@
// circular_doubly_linked_list_engine_unit: node pool holding a circular doubly linked list
// depends on cdll_pkg (request/result structs, codes, default capacity)
//
// sequence after the edge that accepts a beat (start high, busy low):
//   rejected insert, ignored request, insert into empty list: result in the next cycle
//   insert at head or tail: prev read, then two link writes, then the result
//   insert after position p (after the head when p >= count): one next-pointer read
//   per cycle along the list, then two link writes, then the result
//   dump: one result per cycle, count results in all (one value/next read per cycle);
//   busy drops in the cycle the final result shows
// reset: asynchronous active low; list becomes empty, pool memories are not cleared
// results are strobed for one cycle and cannot be stalled by the receiver

module circular_doubly_linked_list_engine_unit #(
    parameter int CAPACITY = cdll_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  cdll_pkg::cdll_req_t req,
    output logic                busy,
    output logic                result_strobe,
    output cdll_pkg::cdll_rsp_t result
);

    // slot index and count widths
    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > cdll_pkg::POS_W) ? CNT_W : cdll_pkg::POS_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAIL,
        ST_WALK,
        ST_LINK1,
        ST_LINK2,
        ST_DUMP
    } state_t;

    // pool memories, one synchronous read port each, read data registered
    logic signed [cdll_pkg::VAL_W-1:0] value_mem [CAPACITY];
    logic [SLOT_W-1:0]                 next_mem  [CAPACITY];
    logic [SLOT_W-1:0]                 prev_mem  [CAPACITY];

    logic signed [cdll_pkg::VAL_W-1:0] value_q;
    logic [SLOT_W-1:0]                 next_q;
    logic [SLOT_W-1:0]                 prev_q;

    // control state
    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [SLOT_W-1:0]   head_reg;
    logic [SLOT_W-1:0]   cur_reg;     // slot whose next pointer is being read
    logic [SLOT_W-1:0]   steps_reg;   // links still to follow
    logic [SLOT_W-1:0]   bef_reg;     // new node goes after this slot
    logic [SLOT_W-1:0]   aft_reg;     // and before this one
    logic [SLOT_W-1:0]   emit_reg;    // results already given in a dump
    logic                strobe_reg;
    cdll_pkg::cdll_rsp_t result_reg;

    // decode of the incoming beat
    logic              accept;
    logic              is_empty;
    logic              is_full;
    logic              is_insert;
    logic              do_write;      // insert that really changes the list
    logic [SLOT_W-1:0] fresh;
    logic [SLOT_W-1:0] target;
    logic              last_emit;

    // memory ports
    logic [SLOT_W-1:0] rd_addr;
    logic              next_we;
    logic [SLOT_W-1:0] next_wa;
    logic [SLOT_W-1:0] next_wd;
    logic              prev_we;
    logic [SLOT_W-1:0] prev_wa;
    logic [SLOT_W-1:0] prev_wd;

    assign accept    = start && (state_reg == ST_IDLE);
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_insert = (req.req_type != cdll_pkg::REQ_DUMP);
    assign do_write  = accept && is_insert && !is_full
                    && !((req.req_type == cdll_pkg::REQ_AFTER) && is_empty);
    // nothing is ever removed, so the next free slot is the count itself
    assign fresh     = SLOT_W'(count_reg);
    // a position at or beyond the count lands on the head
    assign target    = (CMP_W'(req.position) < CMP_W'(count_reg))
                     ? SLOT_W'(req.position) : '0;
    assign last_emit = ((CNT_W'(emit_reg) + CNT_W'(1)) == count_reg);

    // read address: head at start of a walk, tail, or dump; then follow next pointers
    always_comb
    begin
        case (state_reg)
            ST_WALK: rd_addr = next_q;
            ST_DUMP: rd_addr = next_q;
            default: rd_addr = head_reg;
        endcase
    end

    // pointer writes: a node alone links to itself, otherwise splice in ST_LINK1 then ST_LINK2
    always_comb
    begin
        next_we = 1'b0;
        next_wa = fresh;
        next_wd = fresh;
        prev_we = 1'b0;
        prev_wa = fresh;
        prev_wd = fresh;
        case (state_reg)
            ST_IDLE:
            begin
                if (do_write && is_empty)
                begin
                    next_we = 1'b1;
                    prev_we = 1'b1;
                end
            end
            ST_LINK1:
            begin
                next_we = 1'b1;
                next_wa = bef_reg;
                prev_we = 1'b1;
                prev_wa = aft_reg;
            end
            ST_LINK2:
            begin
                next_we = 1'b1;
                next_wd = aft_reg;
                prev_we = 1'b1;
                prev_wd = bef_reg;
            end
            default:
            begin
                next_we = 1'b0;
                prev_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            value_mem[fresh] <= req.value;
        end
        value_q <= value_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        next_q <= next_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        prev_q <= prev_mem[rd_addr];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            head_reg   <= '0;
            cur_reg    <= '0;
            steps_reg  <= '0;
            bef_reg    <= '0;
            aft_reg    <= '0;
            emit_reg   <= '0;
            strobe_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        result_reg.element <= '0;
                        result_reg.last    <= 1'b1;
                        result_reg.length  <= cdll_pkg::LEN_W'(count_reg);
                        if (((req.req_type == cdll_pkg::REQ_DUMP)
                             || (req.req_type == cdll_pkg::REQ_AFTER)) && is_empty)
                        begin
                            result_reg.status <= cdll_pkg::STAT_EMPTY;
                            strobe_reg        <= 1'b1;
                        end
                        else if (req.req_type == cdll_pkg::REQ_DUMP)
                        begin
                            emit_reg  <= '0;
                            state_reg <= ST_DUMP;
                        end
                        else if (is_full)
                        begin
                            result_reg.status <= cdll_pkg::STAT_FULL;
                            strobe_reg        <= 1'b1;
                        end
                        else if (is_empty)
                        begin
                            // first node: self-linked, becomes the head
                            head_reg          <= fresh;
                            count_reg         <= count_reg + CNT_W'(1);
                            result_reg.status <= cdll_pkg::STAT_OK;
                            result_reg.length <= cdll_pkg::LEN_W'(count_reg + CNT_W'(1));
                            strobe_reg        <= 1'b1;
                        end
                        else if (req.req_type == cdll_pkg::REQ_AFTER)
                        begin
                            cur_reg   <= head_reg;
                            steps_reg <= target;
                            state_reg <= ST_WALK;
                        end
                        else
                        begin
                            // head and tail inserts both splice between tail and head
                            if (req.req_type == cdll_pkg::REQ_HEAD)
                            begin
                                head_reg <= fresh;
                            end
                            aft_reg   <= head_reg;
                            state_reg <= ST_TAIL;
                        end
                    end
                end
                ST_TAIL:
                begin
                    bef_reg   <= prev_q;
                    state_reg <= ST_LINK1;
                end
                ST_WALK:
                begin
                    if (steps_reg == '0)
                    begin
                        bef_reg   <= cur_reg;
                        aft_reg   <= next_q;
                        state_reg <= ST_LINK1;
                    end
                    else
                    begin
                        cur_reg   <= next_q;
                        steps_reg <= steps_reg - SLOT_W'(1);
                    end
                end
                ST_LINK1:
                begin
                    state_reg <= ST_LINK2;
                end
                ST_LINK2:
                begin
                    count_reg         <= count_reg + CNT_W'(1);
                    result_reg.status <= cdll_pkg::STAT_OK;
                    result_reg.length <= cdll_pkg::LEN_W'(count_reg + CNT_W'(1));
                    strobe_reg        <= 1'b1;
                    state_reg         <= ST_IDLE;
                end
                ST_DUMP:
                begin
                    // one element per cycle straight from the value read port
                    result_reg.status  <= cdll_pkg::STAT_OK;
                    result_reg.element <= value_q;
                    result_reg.last    <= last_emit;
                    strobe_reg         <= 1'b1;
                    emit_reg           <= emit_reg + SLOT_W'(1);
                    if (last_emit)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule

@@ tb/circular_doubly_linked_list_engine_unit_tb.sv @@
// testbench for circular_doubly_linked_list_engine_unit: directed and random requests,
// results predicted by a scoreboard class holding its own copy of the node pool
// depends on cdll_pkg and the engine rtl only
`timescale 1ns / 1ps

module circular_doubly_linked_list_engine_unit_tb;

    localparam int POOL_SLOTS   = cdll_pkg::CAPACITY_DEF;
    localparam int RANDOM_BEATS = 305;
    localparam int DRAIN_CYCLES = 40;

    // scoreboard: mirrors the list in the pool and queues the results each beat should cause
    class cdll_scoreboard;
        logic signed [cdll_pkg::VAL_W-1:0] slot_value[POOL_SLOTS];
        int unsigned                       slot_next[POOL_SLOTS];
        int unsigned                       slot_prev[POOL_SLOTS];
        int unsigned                       head_slot;
        int unsigned                       list_length;
        cdll_pkg::cdll_rsp_t               awaited[$];
        int                                mismatch_count;

        function new();
            head_slot      = 0;
            list_length    = 0;
            mismatch_count = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // splice fresh between two neighbours; with a single element both are the head
        function void splice(int unsigned fresh, int unsigned prior, int unsigned follower);
            slot_next[prior]    = fresh;
            slot_prev[fresh]    = prior;
            slot_next[fresh]    = follower;
            slot_prev[follower] = fresh;
        endfunction

        // called for each accepted request beat
        function void note_request(cdll_pkg::cdll_req_t r);
            cdll_pkg::cdll_rsp_t rsp;
            int unsigned         walk;
            int unsigned         fresh;
            int unsigned         k;
            rsp      = '0;
            rsp.last = 1'b1;
            if (r.req_type == cdll_pkg::REQ_DUMP)
            begin
                if (list_length == 0)
                begin
                    rsp.status = cdll_pkg::STAT_EMPTY;
                    awaited.push_back(rsp);
                    return;
                end
                walk = head_slot;
                for (k = 0; k < list_length; k++)
                begin
                    rsp.status  = cdll_pkg::STAT_OK;
                    rsp.element = slot_value[walk];
                    rsp.length  = cdll_pkg::LEN_W'(list_length);
                    rsp.last    = (k + 1 == list_length);
                    awaited.push_back(rsp);
                    walk = slot_next[walk];
                end
                return;
            end
            // empty list is reported ahead of a full pool
            if (r.req_type == cdll_pkg::REQ_AFTER && list_length == 0)
            begin
                rsp.status = cdll_pkg::STAT_EMPTY;
                awaited.push_back(rsp);
                return;
            end
            if (list_length >= POOL_SLOTS)
            begin
                rsp.status = cdll_pkg::STAT_FULL;
                rsp.length = cdll_pkg::LEN_W'(list_length);
                awaited.push_back(rsp);
                return;
            end
            // nothing is ever removed, so the new node takes the slot after the last one used
            fresh             = list_length;
            slot_value[fresh] = r.value;
            if (list_length == 0)
            begin
                slot_next[fresh] = fresh;
                slot_prev[fresh] = fresh;
                head_slot        = fresh;
            end
            else if (r.req_type == cdll_pkg::REQ_AFTER)
            begin
                // walk stops early if it wraps back round to the head
                walk = head_slot;
                for (k = 0; k < r.position; k++)
                begin
                    walk = slot_next[walk];
                    if (walk == head_slot)
                        break;
                end
                splice(fresh, walk, slot_next[walk]);
            end
            else
            begin
                splice(fresh, slot_prev[head_slot], head_slot);
                if (r.req_type == cdll_pkg::REQ_HEAD)
                    head_slot = fresh;
            end
            list_length++;
            rsp.status = cdll_pkg::STAT_OK;
            rsp.length = cdll_pkg::LEN_W'(list_length);
            awaited.push_back(rsp);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatch_count++;
        endtask

        // called for each result beat, in order of arrival
        task check_result(cdll_pkg::cdll_rsp_t got);
            cdll_pkg::cdll_rsp_t want;
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing awaited (status %0d element %0d)",
                                          got.status, got.element));
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, predicted %0d", got.status, want.status));
            if (got.element !== want.element)
                report_mismatch($sformatf("element %0d, predicted %0d",
                                          got.element, want.element));
            if (got.length !== want.length)
                report_mismatch($sformatf("length %0d, predicted %0d", got.length, want.length));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0b, predicted %0b", got.last, want.last));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    cdll_pkg::cdll_req_t req;
    logic                busy;
    logic                result_strobe;
    cdll_pkg::cdll_rsp_t result;

    cdll_scoreboard sb;
    int             burst_left;

    circular_doubly_linked_list_engine_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .req           (req),
        .busy          (busy),
        .result_strobe (result_strobe),
        .result        (result)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // every strobed result beat is taken at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
            sb.check_result(result);
    end

    // hard stop in case the block hangs or never raises its strobe
    initial
    begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    // sender idles between bursts of random length; a zero gap keeps start high throughout
    task pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // present one request beat and hold it until the block takes it
    task send_beat(cdll_pkg::cdll_req_t r);
        pace_sender();
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(r);
    endtask

    task send_fields(logic [1:0] kind, logic signed [cdll_pkg::VAL_W-1:0] v,
                     logic [cdll_pkg::POS_W-1:0] p);
        cdll_pkg::cdll_req_t r;
        r.req_type = kind;
        r.value    = v;
        r.position = p;
        send_beat(r);
    endtask

    // values lean on the extremes now and then
    function logic signed [cdll_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(cdll_pkg::VAL_W-1){1'b0}}};
            1:       return {1'b0, {(cdll_pkg::VAL_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        cdll_pkg::cdll_req_t r;
        int                  pick;
        sb         = new();
        burst_left = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        req        = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases first, then each insert kind and both ends of position
        send_fields(cdll_pkg::REQ_DUMP,  '0, '0);
        send_fields(cdll_pkg::REQ_AFTER, 32'sd5, '0);
        send_fields(cdll_pkg::REQ_AFTER, '1, '1);
        send_fields(cdll_pkg::REQ_TAIL,  {1'b0, {(cdll_pkg::VAL_W-1){1'b1}}}, '1);
        send_fields(cdll_pkg::REQ_HEAD,  {1'b1, {(cdll_pkg::VAL_W-1){1'b0}}}, '0);
        send_fields(cdll_pkg::REQ_TAIL,  '0, 6'd3);
        send_fields(cdll_pkg::REQ_TAIL,  '1, '0);
        send_fields(cdll_pkg::REQ_DUMP,  32'sd77, 6'd9);
        send_fields(cdll_pkg::REQ_AFTER, 32'sd1, '0);
        send_fields(cdll_pkg::REQ_AFTER, 32'sd2, '1);
        // after the tail, then at exactly the length (falls back to after the head)
        send_fields(cdll_pkg::REQ_AFTER, 32'sd3, 6'd5);
        send_fields(cdll_pkg::REQ_AFTER, 32'sd4, 6'd7);
        send_fields(cdll_pkg::REQ_HEAD,  32'h5555_5555, 6'h2a);
        send_fields(cdll_pkg::REQ_TAIL,  32'haaaa_aaaa, 6'h15);
        send_fields(cdll_pkg::REQ_AFTER, -32'sd6, 6'd40);
        send_fields(cdll_pkg::REQ_DUMP,  '1, '1);

        // random: inserts fill the pool, after which rejects and full-length dumps take over
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            pick       = $urandom_range(0, 9);
            r.value    = pick_value();
            // mostly positions inside the list, sometimes anywhere in the field
            r.position = ($urandom_range(0, 3) == 0)
                       ? cdll_pkg::POS_W'($urandom_range(0, 63))
                       : cdll_pkg::POS_W'($urandom_range(0, sb.list_length));
            if (pick < 2)
                r.req_type = cdll_pkg::REQ_DUMP;
            else if (pick < 5)
                r.req_type = cdll_pkg::REQ_HEAD;
            else if (pick < 7)
                r.req_type = cdll_pkg::REQ_TAIL;
            else
                r.req_type = cdll_pkg::REQ_AFTER;
            send_beat(r);
        end

        // let the last beats drain, then allow for any stray results
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
